>>> rtl/core/causal_neighbor_window_assert.svh
// Assertion macros used by causal_neighbor_window.
`ifndef CAUSAL_NEIGHBOR_WINDOW_ASSERT_SVH
`define CAUSAL_NEIGHBOR_WINDOW_ASSERT_SVH

// same-cycle implication
`define CNW_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define CNW_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/cnw_pkg.sv
package cnw_pkg;

   localparam int CFG_DATA_BITS  = 32;
   localparam int CFG_ADDR_BITS  = 3;
   localparam int CFG_WIDTH_BITS = 13;
   localparam logic [CFG_WIDTH_BITS-1:0] CFG_WIDTH_RESET = 13'd4096;

   // register index, taken from paddr[2]
   localparam logic REG_IMAGE_WIDTH = 1'b0;

   // control of one pixel cell
   typedef struct packed {
      logic load;
      logic zero;
   } cell_ctrl_type;

endpackage

>>> rtl/core/cnw_line_ram.sv
module cnw_line_ram #(
   parameter int DEPTH     = 4096,
   parameter int DATA_BITS = 8,
   parameter int ADDR_BITS = 12
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [DATA_BITS-1:0] rd_data_a,
   output logic [DATA_BITS-1:0] rd_data_b
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_a_ff;
   logic [DATA_BITS-1:0] rd_b_ff;

   // read returns the old word on a same-edge write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> rtl/core/cnw_cell.sv
module cnw_cell #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                      clock,
   input  cnw_pkg::cell_ctrl_type    ctrl,
   input  logic [PIXEL_BITS-1:0]     data_in,
   output logic [PIXEL_BITS-1:0]     data_out
);

   logic [PIXEL_BITS-1:0] data_ff;
   logic [PIXEL_BITS-1:0] data_in_mux;

   assign data_in_mux = ctrl.zero ? '0 : data_in;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         data_ff <= data_in_mux;
      end
   end

   assign data_out = data_ff;

endmodule

>>> rtl/core/causal_neighbor_window.sv
// causal_neighbor_window
// Takes raster-order pixels on req_* (one beat per pixel, tuser = start of
// image) and returns one rsp_* beat per pixel holding the causal context:
// left, above, above-left, above-right and the pixel itself, with tlast set
// on the last pixel of a row. Neighbors outside the image read as zero.
// Row width is set through the csr_* port (register 0, image_width); write
// it only while no beat is in flight. 0 acts as 1, above MAX_WIDTH as MAX.
// An accepted pixel reaches rsp_* through the stage register, then the output register.
// Throughput: one pixel per clock while rsp_* does not stall, set by the line
// store, which does one write and two reads (above and above-right) per accepted beat.
// Stall: a stage register and the output register sit between the sides;
// with both full and rsp_tready low, req_tready drops and all state holds.
// Reset: clears position to column 0, first row, and empties the pipe.
// The line store needs no clearing pass; reads in the first row are masked to zero.
module causal_neighbor_window #(
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   // input pixels
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((PIXEL_BITS+7)/8)*8-1:0]         req_tdata,  // pixel
   input  logic                                    req_tuser,  // start_image
   // context beats
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // left_neighbor, above_neighbor, above_left_neighbor,
   // above_right_neighbor, current_pixel
   output logic [((5*PIXEL_BITS+7)/8)*8-1:0]       rsp_tdata,
   output logic                                    rsp_tlast,  // row_end
   // register port
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [cnw_pkg::CFG_ADDR_BITS-1:0]       csr_paddr,
   input  logic [cnw_pkg::CFG_DATA_BITS-1:0]       csr_pwdata,
   output logic [cnw_pkg::CFG_DATA_BITS-1:0]       csr_prdata,
   output logic                                    csr_pready
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
   localparam int RSP_W    = ((5*PIXEL_BITS+7)/8)*8;

   // ---------------------------------------------------------------- csr
   logic [cnw_pkg::CFG_WIDTH_BITS-1:0] width_ff;
   logic [cnw_pkg::CFG_WIDTH_BITS-1:0] width_in;
   logic                               csr_wr;
   logic                               csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == cnw_pkg::REG_IMAGE_WIDTH);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready & csr_hit;
   assign width_in   = csr_wr ? csr_pwdata[cnw_pkg::CFG_WIDTH_BITS-1:0] : width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= cnw_pkg::CFG_WIDTH_RESET;
      end else begin
         width_ff <= width_in;
      end
   end

   assign csr_prdata = csr_hit ? cnw_pkg::CFG_DATA_BITS'(width_ff) : '0;

   // effective width, clamped to 1..MAX_WIDTH
   logic [31:0]         width_wide;
   logic [31:0]         width_clamp;
   logic [WID_BITS-1:0] eff_width;

   assign width_wide  = 32'(width_ff);
   assign width_clamp = (width_wide == 32'd0)         ? 32'd1 :
                        (width_wide > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : width_wide;
   assign eff_width   = width_clamp[WID_BITS-1:0];

   // ---------------------------------------------------------- handshake
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance;    // output register free to take the stage beat
   logic s1_move;    // stage beat moves to the output register
   logic accept;

   assign advance     = !out_valid_ff || rsp_tready;
   assign s1_move     = s1_valid_ff && advance;
   assign req_tready  = !s1_valid_ff || advance;
   assign accept      = req_tvalid && req_tready;
   assign s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ----------------------------------------------------------- position
   logic [COL_BITS-1:0] col_ff, col_in;
   logic                first_ff, first_in;
   logic [COL_BITS-1:0] col_cur;
   logic                first_cur;
   logic [WID_BITS-1:0] col_plus;
   logic                last_cur;

   // start of image restarts the position before the context is formed
   assign col_cur   = req_tuser ? '0 : col_ff;
   assign first_cur = req_tuser | first_ff;
   assign col_plus  = WID_BITS'(col_cur) + WID_BITS'(1);
   assign last_cur  = (col_plus >= eff_width);

   always_comb begin
      col_in   = col_ff;
      first_in = first_ff;
      if (accept) begin
         if (last_cur) begin
            col_in   = '0;
            first_in = 1'b0;
         end else begin
            col_in   = col_plus[COL_BITS-1:0];
            first_in = first_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         first_ff <= 1'b1;
      end else begin
         col_ff   <= col_in;
         first_ff <= first_in;
      end
   end

   // stage flags, loaded with the beat
   logic s1_col_zero_ff, s1_first_ff, s1_last_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_zero_ff <= (col_cur == '0);
         s1_first_ff    <= first_cur;
         s1_last_ff     <= last_cur;
      end
   end

   // --------------------------------------------------------- line store
   // holds the current row behind the column, the previous row ahead of it
   logic [PIXEL_BITS-1:0] rd_above;
   logic [PIXEL_BITS-1:0] rd_above_right;

   cnw_line_ram #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (PIXEL_BITS),
      .ADDR_BITS (COL_BITS)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (col_cur),
      .wr_data   (req_tdata[PIXEL_BITS-1:0]),
      .rd_en     (accept),
      .rd_addr_a (col_cur),
      .rd_addr_b (col_plus[COL_BITS-1:0]),
      .rd_data_a (rd_above),
      .rd_data_b (rd_above_right)
   );

   // -------------------------------------------------------- pixel cells
   // current -> left, and masked above -> above-left
   cnw_pkg::cell_ctrl_type cur_ctrl, left_ctrl, ul_ctrl;
   logic [PIXEL_BITS-1:0] cur_pix, left_pix, ul_pix;

   assign cur_ctrl  = '{load: accept,  zero: 1'b0};
   assign left_ctrl = '{load: s1_move, zero: 1'b0};
   assign ul_ctrl   = '{load: s1_move, zero: s1_first_ff};

   cnw_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cur_cell (
      .clock    (clock),
      .ctrl     (cur_ctrl),
      .data_in  (req_tdata[PIXEL_BITS-1:0]),
      .data_out (cur_pix)
   );

   cnw_cell #(.PIXEL_BITS(PIXEL_BITS)) u_left_cell (
      .clock    (clock),
      .ctrl     (left_ctrl),
      .data_in  (cur_pix),
      .data_out (left_pix)
   );

   cnw_cell #(.PIXEL_BITS(PIXEL_BITS)) u_ul_cell (
      .clock    (clock),
      .ctrl     (ul_ctrl),
      .data_in  (rd_above),
      .data_out (ul_pix)
   );

   // ------------------------------------------------------------ context
   logic [PIXEL_BITS-1:0] nb_a, nb_b, nb_c, nb_d;

   assign nb_a = s1_col_zero_ff                  ? '0 : left_pix;
   assign nb_b = s1_first_ff                     ? '0 : rd_above;
   assign nb_c = (s1_first_ff || s1_col_zero_ff) ? '0 : ul_pix;
   assign nb_d = (s1_first_ff || s1_last_ff)     ? '0 : rd_above_right;

   // ------------------------------------------------------ output register
   logic [5*PIXEL_BITS-1:0] rsp_data_ff;
   logic                    rsp_last_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= {cur_pix, nb_d, nb_c, nb_b, nb_a};
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

   // --------------------------------------------------------- assertions
`include "causal_neighbor_window_assert.svh"

   `CNW_ASSERT_IMPL(a_full_blocks_input, clock, reset, s1_valid_ff && out_valid_ff && !rsp_tready, !req_tready)
   `CNW_ASSERT_NEXT(a_row_end_wraps, clock, reset, accept && last_cur, col_ff == '0 && !first_ff)
   `CNW_ASSERT_NEXT(a_start_first_row, clock, reset, accept && req_tuser && !last_cur, first_ff && col_ff == COL_BITS'(1))
   `CNW_ASSERT_IMPL(a_out_from_stage, clock, reset, $rose(rsp_tvalid), $past(s1_valid_ff))

endmodule

>>> sim/tb_causal_neighbor_window.sv
module tb_causal_neighbor_window;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W     = 4096;
   localparam int SETTLE    = 4;     // cycles after the last beat before a register write
   localparam int HOLD_RSP  = 64;    // long output stall, fills the pipe
   localparam int QUIET_MAX = 2000;  // cycles with no beat or register access before giving up
   localparam int RAND_ITEMS = 36;   // pixels per random phase

   // register addresses, index taken from paddr[2]
   localparam logic [cnw_pkg::CFG_ADDR_BITS-1:0] ADDR_WIDTH = {cnw_pkg::REG_IMAGE_WIDTH, 2'b00};
   localparam logic [cnw_pkg::CFG_ADDR_BITS-1:0] ADDR_SPARE = {~cnw_pkg::REG_IMAGE_WIDTH, 2'b00};

   // one context beat as the block should return it
   typedef struct packed {
      logic [7:0] left_nb;
      logic [7:0] above_nb;
      logic [7:0] above_left_nb;
      logic [7:0] above_right_nb;
      logic [7:0] current;
      logic       row_end;
   } pixel_context_type;

   typedef enum logic [1:0] {STEP_PIXEL, STEP_SET_WIDTH, STEP_POKE_SPARE} step_kind_type;

   // directed script row; want is used only when typed is set
   typedef struct packed {
      step_kind_type     kind;
      logic [31:0]       value;
      logic              sop;
      logic              typed;
      pixel_context_type want;
   } script_row_type;

   logic clock;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // pixel
   logic        req_tuser  = 1'b0; // start_image
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // left, above, above_left, above_right, current (8 bits each, lowest first)
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;         // row_end

   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [cnw_pkg::CFG_ADDR_BITS-1:0]   csr_paddr   = '0;
   logic [cnw_pkg::CFG_DATA_BITS-1:0]   csr_pwdata  = '0;
   logic [cnw_pkg::CFG_DATA_BITS-1:0]   csr_prdata;
   logic                                csr_pready;

   causal_neighbor_window #(
      .MAX_WIDTH (MAX_W),
      .PIXEL_BITS(8)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Context predictor: one line store plus position and first-row
   // state. row_mem_valid tracks entries written since reset so the
   // stimulus never makes the block read an unwritten store entry.
   // ---------------------------------------------------------------
   logic [7:0]  row_mem       [MAX_W];
   bit          row_mem_valid [MAX_W];
   int          col_pos       = 0;
   bit          top_row       = 1'b1;
   logic [7:0]  west_pix      = '0;
   logic [7:0]  northwest_pix = '0;
   logic [12:0] width_reg     = cnw_pkg::CFG_WIDTH_RESET;

   pixel_context_type context_q[$];   // contexts still owed by the block

   int failures     = 0;
   int pixels_sent  = 0;
   int images_begun = 0;
   int rows_closed  = 0;
   int input_stalls = 0;

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  hold_rsp       = 1'b0;

   // 0 acts as 1, anything past the store acts as the store size
   function automatic int span();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
   endfunction

   // would the next pixel, without a start of image, read a blank entry?
   function automatic bit reads_blank();
      int c;
      bit ends;
      if (top_row) return 1'b0;
      c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
      ends = (c + 1 >= span());
      return !row_mem_valid[c] || (!ends && !row_mem_valid[c+1]);
   endfunction

   function automatic pixel_context_type predict_context(logic [7:0] pix, bit sop);
      pixel_context_type r;
      int c;
      bit ends;
      logic [7:0] up;
      if (sop) begin
         col_pos = 0;
         top_row = 1'b1;
         west_pix = '0;
         northwest_pix = '0;
      end
      c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
      ends = (c + 1 >= span());   // also covers a width lowered mid-row
      up = top_row ? 8'h00 : row_mem[c];
      r.left_nb        = (c == 0) ? 8'h00 : west_pix;
      r.above_nb       = up;
      r.above_left_nb  = (top_row || c == 0) ? 8'h00 : northwest_pix;
      r.above_right_nb = (top_row || ends) ? 8'h00 : row_mem[c+1];
      r.current        = pix;
      r.row_end        = ends;
      row_mem[c]       = pix;
      row_mem_valid[c] = 1'b1;
      west_pix         = pix;
      northwest_pix    = up;
      if (ends) begin
         col_pos = 0;
         top_row = 1'b0;
      end else begin
         col_pos = c + 1;
      end
      return r;
   endfunction

   function automatic pixel_context_type nb_set(logic [7:0] l, logic [7:0] a, logic [7:0] al,
                                                logic [7:0] ar, logic [7:0] cur, logic last);
      pixel_context_type r;
      r.left_nb        = l;
      r.above_nb       = a;
      r.above_left_nb  = al;
      r.above_right_nb = ar;
      r.current        = cur;
      r.row_end        = last;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   // ---------------------------------------------------------------
   // Output side: compare each accepted context beat with the oldest
   // expectation. Also counts input stall cycles for the summary.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      pixel_context_type want;
      if (!reset) begin
         if (req_tvalid && !req_tready) input_stalls++;
         if (rsp_tvalid && rsp_tready) begin
            if (context_q.size() == 0) begin
               $error("context beat with nothing expected: tdata %0h tlast %0b",
                      rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               want = context_q.pop_front();
               check_field("left_neighbor",        want.left_nb,        rsp_tdata[7:0]);
               check_field("above_neighbor",       want.above_nb,       rsp_tdata[15:8]);
               check_field("above_left_neighbor",  want.above_left_nb,  rsp_tdata[23:16]);
               check_field("above_right_neighbor", want.above_right_nb, rsp_tdata[31:24]);
               check_field("current_pixel",        want.current,        rsp_tdata[39:32]);
               check_field("row_end",              {7'd0, want.row_end}, {7'd0, rsp_tlast});
               if (want.row_end) rows_closed++;
            end
         end
      end
   end

   // output ready: random stalls per phase, plus one long hold on request
   initial begin : rsp_ready_driver
      int n;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (n = 0; n < HOLD_RSP; n++) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: any beat on either side, or a register access, counts as progress
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_MAX) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no beat for %0d cycles, %0d contexts owed", QUIET_MAX,
               context_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------
   // Input side and register port
   // ---------------------------------------------------------------

   // offer one pixel beat; the expectation is queued when the beat is taken
   task automatic offer_pixel(input logic [7:0] pix, input bit sop, input bit typed,
                              input pixel_context_type want);
      pixel_context_type ctx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= sop;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ctx = predict_context(pix, sop);
      context_q.push_back(typed ? want : ctx);
      pixels_sent++;
      if (sop) images_begun++;
   endtask

   // stop offering, wait for every owed context, then let the pipe settle
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (context_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // setup + access, then idle so the next access starts clean
   task automatic csr_write(input logic [cnw_pkg::CFG_ADDR_BITS-1:0] addr,
                            input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr[2] == cnw_pkg::REG_IMAGE_WIDTH) width_reg = data[12:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_width();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_WIDTH;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {19'd0, width_reg}) begin
         $error("image_width readback: expected %0h, got %0h", width_reg, csr_prdata);
         failures++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // register writes happen only with the pipe empty
   task automatic configure(input logic [cnw_pkg::CFG_ADDR_BITS-1:0] addr,
                            input logic [31:0] data);
      drain_pipe();
      csr_write(addr, data);
      csr_check_width();
   endtask

   function automatic logic [12:0] pick_width();
      case ($urandom_range(9))
         0:       return 13'd0;
         1:       return 13'd1;
         2:       return 13'd2;
         3, 4, 5: return 13'($urandom_range(3, 8));
         default: return 13'($urandom_range(9, 40));
      endcase
   endfunction

   script_row_type script[$];

   task automatic add_step(input step_kind_type kind, input logic [31:0] value, input bit sop,
                           input bit typed, input pixel_context_type want);
      script_row_type r;
      r.kind  = kind;
      r.value = value;
      r.sop   = sop;
      r.typed = typed;
      r.want  = want;
      script.push_back(r);
   endtask

   // idle mix per random phase: none, sender only, receiver only, both
   int send_idle_mix [4] = '{0, 66, 0, 38};
   int recv_stall_mix[4] = '{0, 0, 66, 38};

   initial begin : stimulus
      int unsigned n;
      int mode;
      int ph;
      logic [31:0] wdata;
      bit sop;

      // -- directed script --
      // after reset: width 4096, first row, so everything above reads zero
      add_step(STEP_PIXEL, 32'hFF, 1, 1, nb_set(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
      add_step(STEP_PIXEL, 32'h00, 0, 1, nb_set(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 0));
      add_step(STEP_PIXEL, 32'h80, 0, 0, '0);
      // width 0 acts as 1; column 3 is past it, so this pixel closes the row
      add_step(STEP_SET_WIDTH, 32'd0, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h5A, 0, 1, nb_set(8'h80, 8'h00, 8'h00, 8'h00, 8'h5A, 1));
      add_step(STEP_PIXEL, 32'hA5, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h01, 1, 1, nb_set(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 1));
      // width past the store acts as the store size
      add_step(STEP_SET_WIDTH, 32'd8191, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h11, 1, 1, nb_set(8'h00, 8'h00, 8'h00, 8'h00, 8'h11, 0));
      add_step(STEP_PIXEL, 32'h22, 0, 0, '0);
      // upper pwdata bits fall outside the 13-bit register
      add_step(STEP_SET_WIDTH, 32'hFFFF_E003, 0, 0, '0);
      add_step(STEP_PIXEL, 32'hFF, 1, 1, nb_set(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
      add_step(STEP_PIXEL, 32'h00, 0, 0, '0);
      add_step(STEP_PIXEL, 32'hFF, 0, 0, '0);
      // write to an unused index: no effect on width or position
      add_step(STEP_POKE_SPARE, 32'h0000_0001, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h00, 0, 0, '0);
      add_step(STEP_PIXEL, 32'hFF, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h00, 0, 0, '0);
      // width lowered mid-row: column 3 of a width-4 image, then width 2
      add_step(STEP_SET_WIDTH, 32'd4, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h3C, 1, 1, nb_set(8'h00, 8'h00, 8'h00, 8'h00, 8'h3C, 0));
      add_step(STEP_PIXEL, 32'hC3, 0, 0, '0);
      add_step(STEP_PIXEL, 32'hFF, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h00, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h7E, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h81, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h42, 0, 0, '0);
      add_step(STEP_SET_WIDTH, 32'd2, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h99, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h66, 0, 0, '0);
      add_step(STEP_PIXEL, 32'h18, 0, 0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         case (script[i].kind)
            STEP_PIXEL:      offer_pixel(script[i].value[7:0], script[i].sop, script[i].typed,
                                         script[i].want);
            STEP_SET_WIDTH:  configure(ADDR_WIDTH, script[i].value);
            STEP_POKE_SPARE: configure(ADDR_SPARE, script[i].value);
            default: ;
         endcase
      end

      // -- random phases: small widths, random idling; one long output hold --
      for (mode = 0; mode < 4; mode++) begin
         send_idle_pct  = send_idle_mix[mode];
         recv_stall_pct = recv_stall_mix[mode];
         for (ph = 0; ph < 4; ph++) begin
            if ($urandom_range(3) == 0) configure(ADDR_SPARE, $urandom);
            wdata = $urandom;
            if ($urandom_range(1)) wdata[31:13] = '0;
            wdata[12:0] = pick_width();
            configure(ADDR_WIDTH, wdata);
            // receiver-only phase: hold output long while pixels keep coming
            if (mode == 2 && ph == 0) hold_rsp = 1'b1;
            for (n = 0; n < RAND_ITEMS; n++) begin
               sop = ($urandom_range(39) == 0) || (n == 0 && $urandom_range(1));
               // a width raised since the rows above were written needs a new image
               if (!sop && reads_blank()) sop = 1'b1;
               offer_pixel(8'($urandom_range(255)), sop, 0, '0);
            end
         end
      end

      drain_pipe();
      repeat (8) @(posedge clock);

      $display("covered %0d pixel beats over %0d images, %0d row ends, widths 0 to 8191",
               pixels_sent, images_begun, rows_closed);
      $display("input held off %0d cycles by output backpressure", input_stalls);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
